// ----- sv/dosk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dosk_pkg - shared types and tables for the pad-driven on-screen keyboard
// Transaction payloads, op codes, key grid geometry and the scancode ROM.
// ----------------------------------------------------------------------------
package dosk_pkg;

  localparam int unsigned NUM_ROWS = 5;
  localparam int unsigned MAX_COLS = 12;
  localparam int unsigned ROM_DEPTH = NUM_ROWS * MAX_COLS;
  localparam int unsigned ROM_AW = $clog2(ROM_DEPTH);

  // op codes
  localparam logic [1:0] OP_PAD    = 2'd0;
  localparam logic [1:0] OP_TOGGLE = 2'd1;
  localparam logic [1:0] OP_EXT    = 2'd2;
  localparam logic [1:0] OP_SLOT   = 2'd3;

  // reserved key codes
  localparam logic [7:0] CODE_CLOSE = 8'hFF;
  localparam logic [7:0] CODE_UART  = 8'hFE;

  // pad bit positions
  localparam int unsigned PAD_UP    = 0;
  localparam int unsigned PAD_DOWN  = 1;
  localparam int unsigned PAD_LEFT  = 2;
  localparam int unsigned PAD_RIGHT = 3;
  localparam int unsigned PAD_A     = 6;

  localparam logic [2:0] LAST_ROW = 3'(NUM_ROWS - 1);

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] pad;
    logic [7:0] ext_scancode;
  } in_item_t;

  typedef struct packed {
    logic       used;
    logic       key_posted;
    logic [7:0] scancode;
    logic [7:0] sequence_res;
    logic       active;
    logic [2:0] cursor_row;
    logic [3:0] cursor_col;
    logic       redraw;
    logic       uart_toggle;
    logic       slot_free;
  } out_item_t;

  // row-major scancode table, unused slots are zero
  localparam logic [7:0] SCAN_ROM [ROM_DEPTH] = '{
    8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h00, 8'h00,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h00, 8'h00,
    8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h00, 8'h00, 8'h00,
    8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32, 8'h34, 8'h0C, 8'h00, 8'h00, 8'h00,
    8'h2A, 8'h39, 8'h0D, 8'h0E, 8'h1C, 8'h4B, 8'h50, 8'h48, 8'h4D, 8'h01, CODE_CLOSE,
    CODE_UART
  };

  // keys per row
  function automatic logic [3:0] row_len(input logic [2:0] row);
    logic [3:0] len;
    case (row)
      3'd0, 3'd1: len = 4'd10;
      3'd2, 3'd3: len = 4'd9;
      default:    len = 4'd12;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] scan_lookup(input logic [2:0] row, input logic [3:0] col);
    logic [6:0] idx;
    logic [7:0] code;
    idx = 7'(row) * 7'(MAX_COLS) + 7'(col);
    if (row < 3'(NUM_ROWS) && col < 4'(MAX_COLS)) begin
      code = SCAN_ROM[idx[ROM_AW-1:0]];
    end else begin
      code = 8'h00;
    end
    return code;
  endfunction

endpackage

// ----- sv/dosk_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dosk_chan_if - valid/ready channel
// Carries one payload per transaction; accepted when valid and ready are high.
// ----------------------------------------------------------------------------
interface dosk_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/dpad_onscreen_keyboard_selector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpad_onscreen_keyboard_selector_core - pad-driven on-screen keyboard cursor
// Edge-detects pad frames, moves a cursor over a 5-row key grid, posts
// scancodes with a wrapping sequence number and tracks the posted-slot flag.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------
//  in_ch   | in  | valid/ready          | op, pad, ext_scancode
//  out_ch  | out | valid/ready          | used, key_posted, scancode, sequence_res,
//          |     |                      | active, cursor_row, cursor_col, redraw,
//          |     |                      | uart_toggle, slot_free
//
//  The state update and result are computed in one pass of combinational
//  logic from the accepted item and land in the output register on the
//  accepting edge, or in the skid register while the output is stalled.
//  Sustained rate is one item per cycle while the sink keeps up.
//  A two-entry output (result register plus skid register) lets one more item
//  in while a result is stalled; in_ch.ready drops only when both are full.
//  rst_n is synchronous, active low; it clears all architectural state and both valid bits.
//
module dpad_onscreen_keyboard_selector_core (
  input  logic      clk,
  input  logic      rst_n,
  dosk_chan_if.sink   in_ch,
  dosk_chan_if.source out_ch
);
  import dosk_pkg::*;

  // architectural state
  logic [7:0] prev_pad_r,   prev_pad_nxt;
  logic       shown_r,      shown_nxt;
  logic [2:0] row_r,        row_nxt;
  logic [3:0] col_r,        col_nxt;
  logic [7:0] post_count_r, post_count_nxt;
  logic       slot_taken_r, slot_taken_nxt;

  // output register and skid stage
  logic      out_valid_r, skid_valid_r;
  out_item_t out_data_r,  skid_data_r;

  in_item_t  item;
  out_item_t res_nxt;
  logic      in_acc, out_acc;

  logic [7:0] pad_edge;
  logic [7:0] code;
  logic [3:0] len;

  assign item    = in_ch.payload;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_valid_r && out_ch.ready;

  // room as long as the skid stage is empty
  assign in_ch.ready    = !skid_valid_r;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

  assign pad_edge = item.pad & ~prev_pad_r;

  // -------------------------------------------------------------------------
  // Single-pass item evaluation. Moves are applied in order left, right, up,
  // down; A reads the cursor after all moves.
  // -------------------------------------------------------------------------
  always_comb begin
    prev_pad_nxt   = prev_pad_r;
    shown_nxt      = shown_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    post_count_nxt = post_count_r;
    slot_taken_nxt = slot_taken_r;
    res_nxt        = '0;
    code           = 8'h00;
    len            = row_len(row_r);

    case (item.op)
      OP_PAD: begin
        prev_pad_nxt = item.pad;
        if (shown_r) begin
          res_nxt.used = 1'b1;
          if (pad_edge[PAD_LEFT]) begin
            if (col_nxt != 4'd0) col_nxt = col_nxt - 4'd1;
            res_nxt.redraw = 1'b1;
          end
          if (pad_edge[PAD_RIGHT]) begin
            if (col_nxt + 4'd1 < len) col_nxt = col_nxt + 4'd1;
            res_nxt.redraw = 1'b1;
          end
          if (pad_edge[PAD_UP]) begin
            if (row_nxt != 3'd0) row_nxt = row_nxt - 3'd1;
            len = row_len(row_nxt);
            if (col_nxt >= len) col_nxt = len - 4'd1;
            res_nxt.redraw = 1'b1;
          end
          if (pad_edge[PAD_DOWN]) begin
            if (row_nxt < LAST_ROW) row_nxt = row_nxt + 3'd1;
            len = row_len(row_nxt);
            if (col_nxt >= len) col_nxt = len - 4'd1;
            res_nxt.redraw = 1'b1;
          end
          if (pad_edge[PAD_A]) begin
            code = scan_lookup(row_nxt, col_nxt);
            if (code == CODE_CLOSE) begin
              shown_nxt = 1'b0;
            end else if (code == CODE_UART) begin
              res_nxt.uart_toggle = 1'b1;
              res_nxt.redraw      = 1'b1;
            end else begin
              post_count_nxt       = post_count_r + 8'd1;
              slot_taken_nxt       = 1'b1;
              res_nxt.key_posted   = 1'b1;
              res_nxt.scancode     = code;
              res_nxt.sequence_res = post_count_nxt;
            end
          end
        end
      end
      OP_TOGGLE: begin
        shown_nxt      = !shown_r;
        res_nxt.redraw = !shown_r;
      end
      OP_EXT: begin
        post_count_nxt       = post_count_r + 8'd1;
        slot_taken_nxt       = 1'b1;
        res_nxt.key_posted   = 1'b1;
        res_nxt.scancode     = item.ext_scancode;
        res_nxt.sequence_res = post_count_nxt;
      end
      OP_SLOT: begin
        res_nxt.slot_free = !slot_taken_r;
        slot_taken_nxt    = 1'b0;
      end
      default: begin
        res_nxt = '0;
      end
    endcase

    res_nxt.active     = shown_nxt;
    res_nxt.cursor_row = row_nxt;
    res_nxt.cursor_col = col_nxt;
  end

  // state advances on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pad_r   <= '0;
      shown_r      <= 1'b0;
      row_r        <= '0;
      col_r        <= '0;
      post_count_r <= '0;
      slot_taken_r <= 1'b0;
    end else if (in_acc) begin
      prev_pad_r   <= prev_pad_nxt;
      shown_r      <= shown_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      post_count_r <= post_count_nxt;
      slot_taken_r <= slot_taken_nxt;
    end
  end

  // output register with skid: new result goes to the output register when
  // it frees up this cycle, else parks in the skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_acc) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_acc) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_acc) begin
        out_data_r <= res_nxt;
      end
    end else if (in_acc) begin
      skid_data_r <= res_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= LAST_ROW)
    else $error("cursor row out of grid");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < row_len(row_r))
    else $error("cursor column past end of row");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result ahead of the output register");

  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_nxt.key_posted) |=> (post_count_r == $past(post_count_r) + 8'd1))
    else $error("sequence number did not advance on post");

  a_slot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && item.op == OP_SLOT) |=> !slot_taken_r)
    else $error("slot flag not cleared by slot check");

endmodule

// ----- dv/tb_dpad_onscreen_keyboard_selector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dpad_onscreen_keyboard_selector_core - self-checking bench for the core
// Sends pad frames and control ops, predicts each report with a behavioral
// keyboard tracker, and checks every report field by field, in order.
// ----------------------------------------------------------------------------
module tb_dpad_onscreen_keyboard_selector_core;
  import dosk_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SHOWN   = 10;

  // pad masks built from the package bit positions
  localparam logic [7:0] BTN_UP    = 8'(1) << PAD_UP;
  localparam logic [7:0] BTN_DOWN  = 8'(1) << PAD_DOWN;
  localparam logic [7:0] BTN_LEFT  = 8'(1) << PAD_LEFT;
  localparam logic [7:0] BTN_RIGHT = 8'(1) << PAD_RIGHT;
  localparam logic [7:0] BTN_A     = 8'(1) << PAD_A;
  // bits that never move the cursor or press a key
  localparam logic [7:0] BTN_OTHER = ~(BTN_UP | BTN_DOWN | BTN_LEFT | BTN_RIGHT | BTN_A);

  localparam int KEYS_PER_ROW [NUM_ROWS] = '{10, 10, 9, 9, 12};

  typedef enum logic [1:0] {
    SINK_OPEN,      // always ready
    SINK_COIN,      // ready half the time
    SINK_SLOW,      // ready a quarter of the time, at random
    SINK_PERIODIC   // fixed duty pattern off the cycle counter
  } sink_mode_t;

  logic clk;
  logic rst_n;

  dosk_chan_if #(.payload_t(in_item_t))  in_ch ();
  dosk_chan_if #(.payload_t(out_item_t)) out_ch ();

  dpad_onscreen_keyboard_selector_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // --------------------------------------------------------------------------
  // Stimulus and scoreboard storage
  // --------------------------------------------------------------------------
  in_item_t  frames_to_send [$];   // filled by the sequencer, drained by the driver
  out_item_t awaited_reports [$];  // predicted reports, oldest first

  int cycle_count    = 0;
  int frames_queued  = 0;
  int frames_taken   = 0;
  int fail_count     = 0;
  int mismatch_count = 0;
  bit in_took        = 1'b0;      // input transaction at the last rising edge

  // --------------------------------------------------------------------------
  // Keyboard tracker: mirrors the core's state, reset values all zero
  // --------------------------------------------------------------------------
  logic [7:0] kb_prev_pad   = '0;
  logic       kb_shown      = 1'b0;
  logic [2:0] kb_row        = '0;
  logic [3:0] kb_col        = '0;
  logic [7:0] kb_seq        = '0;
  logic       kb_slot_taken = 1'b0;

  // keep the column on a real key after a row change
  function automatic void clamp_column();
    if (int'(kb_col) >= KEYS_PER_ROW[kb_row]) begin
      kb_col = 4'(KEYS_PER_ROW[kb_row] - 1);
    end
  endfunction

  // publish a scancode: bump the wrapping sequence, mark the frame slot taken
  function automatic out_item_t with_posted_key(input out_item_t rpt, input logic [7:0] code);
    out_item_t r;
    r = rpt;
    kb_seq = kb_seq + 8'd1;
    kb_slot_taken = 1'b1;
    r.key_posted = 1'b1;
    r.scancode = code;
    r.sequence_res = kb_seq;
    return r;
  endfunction

  function automatic out_item_t next_keyboard_report(input in_item_t it);
    out_item_t  r;
    logic [7:0] rise;
    logic [7:0] code;
    r = '0;
    case (it.op)
      OP_PAD: begin
        // edge history is kept even while hidden
        rise = it.pad & ~kb_prev_pad;
        kb_prev_pad = it.pad;
        if (kb_shown) begin
          r.used = 1'b1;
          // fixed priority: left, right, up, down, then A on the final cursor
          if (rise[PAD_LEFT]) begin
            if (kb_col != 0) kb_col = kb_col - 4'd1;
            r.redraw = 1'b1;
          end
          if (rise[PAD_RIGHT]) begin
            if (int'(kb_col) + 1 < KEYS_PER_ROW[kb_row]) kb_col = kb_col + 4'd1;
            r.redraw = 1'b1;
          end
          if (rise[PAD_UP]) begin
            if (kb_row != 0) kb_row = kb_row - 3'd1;
            clamp_column();
            r.redraw = 1'b1;
          end
          if (rise[PAD_DOWN]) begin
            if (kb_row < LAST_ROW) kb_row = kb_row + 3'd1;
            clamp_column();
            r.redraw = 1'b1;
          end
          if (rise[PAD_A]) begin
            code = SCAN_ROM[int'(kb_row) * MAX_COLS + int'(kb_col)];
            if (code == CODE_CLOSE) begin
              kb_shown = 1'b0;      // redraw left as the moves set it
            end else if (code == CODE_UART) begin
              r.uart_toggle = 1'b1;
              r.redraw = 1'b1;
            end else begin
              r = with_posted_key(r, code);
            end
          end
        end
      end
      OP_TOGGLE: begin
        kb_shown = ~kb_shown;
        if (kb_shown) r.redraw = 1'b1;
      end
      OP_EXT: begin
        // serial path posts regardless of visibility
        r = with_posted_key(r, it.ext_scancode);
      end
      default: begin
        // OP_SLOT: test and clear
        r.slot_free = ~kb_slot_taken;
        kb_slot_taken = 1'b0;
      end
    endcase
    r.active = kb_shown;
    r.cursor_row = kb_row;
    r.cursor_col = kb_col;
    return r;
  endfunction

  function automatic string report_text(input out_item_t r);
    return $sformatf({"used=%0b posted=%0b code=%02h seq=%02h active=%0b row=%0d col=%0d ",
                      "redraw=%0b uart=%0b free=%0b"},
                     r.used, r.key_posted, r.scancode, r.sequence_res, r.active,
                     r.cursor_row, r.cursor_col, r.redraw, r.uart_toggle, r.slot_free);
  endfunction

  task automatic queue_frame(input logic [1:0] op, input logic [7:0] pad,
                             input logic [7:0] code);
    in_item_t it;
    it.op = op;
    it.pad = pad;
    it.ext_scancode = code;
    frames_to_send.push_back(it);
    frames_queued++;
  endtask

  // pause the sequencer until the core has returned every report
  task automatic wait_drained();
    while (frames_taken != frames_queued || awaited_reports.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset; every core input gets a known value at time zero
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    fork
      forever #5 clk = ~clk;
    join_none
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;   // nonblocking: the driver still sees reset on this edge
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of back-to-back transactions separated by random gaps.
  // Valid holds with the same payload until the transaction is taken.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (gap_left != 0 || frames_to_send.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.payload <= frames_to_send.pop_front();
        in_ch.valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          // a quarter of bursts run straight into the next one
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink backpressure: a mode is drawn for a random stretch of cycles
  // --------------------------------------------------------------------------
  sink_mode_t sink_mode = SINK_OPEN;
  int         sink_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_left = $urandom_range(20, 80);
      end else begin
        sink_left--;
      end
      case (sink_mode)
        SINK_OPEN: out_ch.ready <= 1'b1;
        SINK_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
        SINK_SLOW: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= ((cycle_count % 7) < 4);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: the output side is checked before the same edge's input is
  // predicted, since a report can never belong to an item taken on its edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    cycle_count++;
    if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_reports.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $display("unexpected report: %s", report_text(out_ch.payload));
          end
        end else begin
          want = awaited_reports.pop_front();
          if (out_ch.payload.used         !== want.used         ||
              out_ch.payload.key_posted   !== want.key_posted   ||
              out_ch.payload.scancode     !== want.scancode     ||
              out_ch.payload.sequence_res !== want.sequence_res ||
              out_ch.payload.active       !== want.active       ||
              out_ch.payload.cursor_row   !== want.cursor_row   ||
              out_ch.payload.cursor_col   !== want.cursor_col   ||
              out_ch.payload.redraw       !== want.redraw       ||
              out_ch.payload.uart_toggle  !== want.uart_toggle  ||
              out_ch.payload.slot_free    !== want.slot_free) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN) begin
              $display("report mismatch at cycle %0d", cycle_count);
              $display("  expected: %s", report_text(want));
              $display("  actual:   %s", report_text(out_ch.payload));
            end
          end
        end
      end
      in_took = in_ch.valid && in_ch.ready;
      if (in_took) begin
        awaited_reports.push_back(next_keyboard_report(in_ch.payload));
        frames_taken++;
      end
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("dpad_onscreen_keyboard_selector_core verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    int         pick;
    logic [7:0] press;

    // Directed: hidden frames, no-edge holds, all edges at once, walk to the
    // far corner of the bottom row, then the UART and close keys.
    queue_frame(OP_PAD, 8'hFF, 8'h00);          // hidden: only remembered
    queue_frame(OP_SLOT, 8'h00, 8'h00);         // nothing posted yet
    queue_frame(OP_TOGGLE, 8'h00, 8'hFF);       // show
    queue_frame(OP_PAD, BTN_UP | BTN_LEFT, 8'h00);  // still held: no edges
    queue_frame(OP_PAD, BTN_OTHER, 8'h00);      // non-nav bits only
    queue_frame(OP_PAD, BTN_A | BTN_DOWN | BTN_RIGHT | BTN_UP | BTN_LEFT, 8'h00);
    queue_frame(OP_SLOT, 8'h00, 8'h00);         // slot taken by the A press
    queue_frame(OP_PAD, 8'h00, 8'h00);
    // alternating directions give one edge per frame
    for (int i = 0; i < 3; i++) begin
      queue_frame(OP_PAD, BTN_DOWN, 8'h00);
      queue_frame(OP_PAD, BTN_RIGHT, 8'h00);
    end
    // down at the last row still requests a redraw
    for (int i = 0; i < 7; i++) begin
      queue_frame(OP_PAD, BTN_RIGHT, 8'h00);
      if (i < 6) queue_frame(OP_PAD, BTN_DOWN, 8'h00);
    end
    queue_frame(OP_PAD, BTN_A, 8'h00);          // UART key
    queue_frame(OP_PAD, BTN_LEFT, 8'h00);
    queue_frame(OP_PAD, BTN_A, 8'h00);          // close key hides
    queue_frame(OP_EXT, 8'h00, 8'hFF);          // external post while hidden
    wait_drained();

    // Mixed random: mostly press/release gestures with random content,
    // plus toggles, external posts, slot checks and raw noise frames.
    for (int n = 0; n < 250; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        press = 8'($urandom);
        press[PAD_A] = ($urandom_range(0, 3) == 0);
        queue_frame(OP_PAD, press, 8'($urandom));
        if ($urandom_range(0, 3) != 0) begin
          queue_frame(OP_PAD, 8'($urandom) & BTN_OTHER, 8'($urandom));
        end else begin
          queue_frame(OP_PAD, press, 8'($urandom));   // held frame
        end
        n++;
      end else if (pick < 60) begin
        queue_frame(OP_TOGGLE, 8'($urandom), 8'($urandom));
      end else if (pick < 78) begin
        queue_frame(OP_EXT, 8'($urandom), 8'($urandom));
      end else if (pick < 88) begin
        queue_frame(OP_SLOT, 8'($urandom), 8'($urandom));
      end else begin
        queue_frame(OP_PAD, 8'($urandom), 8'($urandom));
      end
    end
    // hold off until the core is empty before the next phase
    wait_drained();

    // Post-heavy random: carries the sequence number through its wrap.
    for (int n = 0; n < 260; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        queue_frame(OP_EXT, 8'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        queue_frame(OP_SLOT, 8'($urandom), 8'($urandom));
      end else if (pick < 94) begin
        queue_frame(OP_TOGGLE, 8'($urandom), 8'($urandom));
      end else begin
        queue_frame(OP_PAD, 8'($urandom), 8'($urandom));
      end
    end
    wait_drained();

    // a few more edges to catch any stray report
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("dpad_onscreen_keyboard_selector_core verification clean");
    end else begin
      $display("dpad_onscreen_keyboard_selector_core verification failed");
    end
    $finish;
  end

endmodule
